// File: hdl/touch_sample_calibrate_core_defines.svh
// ----------------------------------------------------------------------------
// Touch sample calibration core: assertion macros
// Shared property macros; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TOUCH_SAMPLE_CALIBRATE_CORE_DEFINES_SVH
`define TOUCH_SAMPLE_CALIBRATE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion %m failed.");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("Assertion %m failed.");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: hdl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample calibration package
// Widths, register codes and the records that travel down the pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int RES_W       = 13;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = COEF_W + SAMPLE_W + 1;
    localparam int SUM_W       = PROD_W + 2;
    localparam int MAG_W       = SUM_W;
    localparam int DIVM_W      = COEF_W;
    localparam int QUO_W       = SAMPLE_W;
    localparam int RES_PROD_W  = 2 * SAMPLE_W + 1;
    localparam int REG_IDX_W   = 3;
    localparam int IN_W        = 4 * SAMPLE_W;
    localparam int OUT_W       = 2 * SAMPLE_W + RES_W + 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COEF_A,
        REG_COEF_B,
        REG_COEF_C,
        REG_COEF_D,
        REG_COEF_E,
        REG_COEF_F,
        REG_DIVISOR,
        REG_RAW_MODE
    } reg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic signed [COEF_W-1:0] coef_e;
        logic signed [COEF_W-1:0] coef_f;
        logic signed [COEF_W-1:0] divisor;
        logic                     raw_mode;
    } calib_cfg_t;

    localparam calib_cfg_t CFG_RESET = '{
        coef_a:   32'sd380680,
        coef_b:   -32'sd728,
        coef_c:   -32'sd1484942016,
        coef_d:   -32'sd11440,
        coef_e:   32'sd286864,
        coef_f:   -32'sd1080423872,
        divisor:  -32'sd4265432,
        raw_mode: 1'b0
    };

    // One calibration row during division: remainder, quotient so far,
    // whether the true quotient is non-negative, and quotient overflow.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             pos;
        logic             ovf;
    } axis_div_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_x;
        logic [SAMPLE_W-1:0] raw_y;
        axis_div_t           ax;
        axis_div_t           ay;
        logic                res_valid;
        logic                res_neg;
        logic [SAMPLE_W-1:0] res_rem;
        logic [SAMPLE_W-1:0] res_den;
        logic [QUO_W-1:0]    res_quo;
    } div_word_t;

    typedef struct packed {
        logic                    calib_error;
        logic                    pressed;
        logic                    resistance_valid;
        logic signed [RES_W-1:0] touch_resistance;
        logic [SAMPLE_W-1:0]     pos_y;
        logic [SAMPLE_W-1:0]     pos_x;
    } result_t;

endpackage

// File: hdl/tsc_front.sv
// ----------------------------------------------------------------------------
// Touch sample calibration front end
// Three stages: products, row sums, and magnitudes with quotient signs.
// ----------------------------------------------------------------------------
module tsc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tsc_pkg::SAMPLE_W-1:0] sample_x,
    input  logic [tsc_pkg::SAMPLE_W-1:0] sample_y,
    input  logic [tsc_pkg::SAMPLE_W-1:0] pressure_z1,
    input  logic [tsc_pkg::SAMPLE_W-1:0] pressure_z2,
    input  tsc_pkg::calib_cfg_t          cfg,
    output logic                         out_valid,
    output tsc_pkg::div_word_t           out_word
);
    import tsc_pkg::*;

    logic                         valid1_reg;
    logic signed [PROD_W-1:0]     prod_ax_reg;
    logic signed [PROD_W-1:0]     prod_by_reg;
    logic signed [PROD_W-1:0]     prod_dx_reg;
    logic signed [PROD_W-1:0]     prod_ey_reg;
    logic signed [RES_PROD_W-1:0] res_prod_reg;
    logic [SAMPLE_W-1:0]          raw_x1_reg;
    logic [SAMPLE_W-1:0]          raw_y1_reg;
    logic [SAMPLE_W-1:0]          z2_1_reg;

    logic                         valid2_reg;
    logic signed [SUM_W-1:0]      sum_x_reg;
    logic signed [SUM_W-1:0]      sum_y_reg;
    logic                         res_neg2_reg;
    logic [SAMPLE_W-1:0]          res_num2_reg;
    logic [SAMPLE_W-1:0]          raw_x2_reg;
    logic [SAMPLE_W-1:0]          raw_y2_reg;
    logic [SAMPLE_W-1:0]          z2_2_reg;

    logic                         valid3_reg;
    div_word_t                    word3_reg;

    logic signed [SAMPLE_W:0]     dz;
    logic signed [SAMPLE_W:0]     x_s;
    logic signed [SAMPLE_W:0]     y_s;
    logic signed [PROD_W-1:0]     prod_ax_next;
    logic signed [PROD_W-1:0]     prod_by_next;
    logic signed [PROD_W-1:0]     prod_dx_next;
    logic signed [PROD_W-1:0]     prod_ey_next;
    logic signed [RES_PROD_W-1:0] res_prod_next;
    logic signed [SUM_W-1:0]      sum_x_next;
    logic signed [SUM_W-1:0]      sum_y_next;
    logic [RES_PROD_W-1:0]        res_mag;
    logic [MAG_W-1:0]             mag_x;
    logic [MAG_W-1:0]             mag_y;
    div_word_t                    word3_next;

    assign x_s  = $signed({1'b0, sample_x});
    assign y_s  = $signed({1'b0, sample_y});
    assign dz   = $signed({1'b0, pressure_z1} - {1'b0, pressure_z2});

    assign prod_ax_next  = PROD_W'(cfg.coef_a) * PROD_W'(x_s);
    assign prod_by_next  = PROD_W'(cfg.coef_b) * PROD_W'(y_s);
    assign prod_dx_next  = PROD_W'(cfg.coef_d) * PROD_W'(x_s);
    assign prod_ey_next  = PROD_W'(cfg.coef_e) * PROD_W'(y_s);
    assign res_prod_next = RES_PROD_W'(x_s) * RES_PROD_W'(dz);

    assign sum_x_next = SUM_W'(prod_ax_reg) + SUM_W'(prod_by_reg) + SUM_W'(cfg.coef_c);
    assign sum_y_next = SUM_W'(prod_dx_reg) + SUM_W'(prod_ey_reg) + SUM_W'(cfg.coef_f);
    assign res_mag    = res_prod_reg[RES_PROD_W-1] ? RES_PROD_W'(-res_prod_reg)
                                                   : RES_PROD_W'(res_prod_reg);

    assign mag_x = sum_x_reg[SUM_W-1] ? MAG_W'(-sum_x_reg) : MAG_W'(sum_x_reg);
    assign mag_y = sum_y_reg[SUM_W-1] ? MAG_W'(-sum_y_reg) : MAG_W'(sum_y_reg);

    always_comb
    begin
        word3_next.raw_x     = raw_x2_reg;
        word3_next.raw_y     = raw_y2_reg;
        word3_next.ax.rem    = mag_x;
        word3_next.ax.quo    = '0;
        word3_next.ax.pos    = (sum_x_reg[SUM_W-1] == cfg.divisor[COEF_W-1]);
        word3_next.ax.ovf    = 1'b0;
        word3_next.ay.rem    = mag_y;
        word3_next.ay.quo    = '0;
        word3_next.ay.pos    = (sum_y_reg[SUM_W-1] == cfg.divisor[COEF_W-1]);
        word3_next.ay.ovf    = 1'b0;
        word3_next.res_valid = (z2_2_reg != '0);
        word3_next.res_neg   = res_neg2_reg;
        word3_next.res_rem   = res_num2_reg;
        word3_next.res_den   = z2_2_reg;
        word3_next.res_quo   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_ax_reg  <= prod_ax_next;
            prod_by_reg  <= prod_by_next;
            prod_dx_reg  <= prod_dx_next;
            prod_ey_reg  <= prod_ey_next;
            res_prod_reg <= res_prod_next;
            raw_x1_reg   <= sample_x;
            raw_y1_reg   <= sample_y;
            z2_1_reg     <= pressure_z2;

            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            res_neg2_reg <= res_prod_reg[RES_PROD_W-1];
            res_num2_reg <= res_mag[2*SAMPLE_W-1:SAMPLE_W];
            raw_x2_reg   <= raw_x1_reg;
            raw_y2_reg   <= raw_y1_reg;
            z2_2_reg     <= z2_1_reg;

            word3_reg    <= word3_next;
        end
    end

    assign out_valid = valid3_reg;
    assign out_word  = word3_reg;

endmodule

// File: hdl/tsc_divider.sv
// ----------------------------------------------------------------------------
// Touch sample calibration divider
// Overflow check followed by one restoring quotient bit per stage for both
// calibration rows and the touch resistance.
// ----------------------------------------------------------------------------
module tsc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [tsc_pkg::DIVM_W-1:0] div_mag,
    input  logic                       in_valid,
    input  tsc_pkg::div_word_t         in_word,
    output logic                       out_valid,
    output tsc_pkg::div_word_t         out_word
);
    import tsc_pkg::*;

    localparam int STAGES = QUO_W + 1;

    logic      valid_reg [STAGES];
    div_word_t word_reg  [STAGES];
    logic      valid_prev[STAGES];
    div_word_t word_next [STAGES];

    // A quotient that would not fit in the result width saturates later.
    function automatic div_word_t ovf_check(input div_word_t w,
                                            input logic [DIVM_W-1:0] dm);
        div_word_t        r;
        logic [MAG_W-1:0] lim;
        r        = w;
        lim      = MAG_W'({dm, {QUO_W{1'b0}}});
        r.ax.ovf = (w.ax.rem >= lim);
        r.ay.ovf = (w.ay.rem >= lim);
        return r;
    endfunction

    function automatic axis_div_t axis_step(input axis_div_t a,
                                            input logic [DIVM_W-1:0] dm,
                                            input int bit_idx);
        axis_div_t        r;
        logic [MAG_W-1:0] sub;
        r   = a;
        sub = MAG_W'(dm) << bit_idx;
        if (a.rem >= sub)
        begin
            r.rem = a.rem - sub;
            r.quo = a.quo | (QUO_W'(1) << bit_idx);
        end
        return r;
    endfunction

    function automatic div_word_t div_step(input div_word_t w,
                                           input logic [DIVM_W-1:0] dm,
                                           input int bit_idx);
        div_word_t             r;
        logic [2*SAMPLE_W-1:0] rsub;
        logic [2*SAMPLE_W-1:0] rrem;
        r    = w;
        r.ax = axis_step(w.ax, dm, bit_idx);
        r.ay = axis_step(w.ay, dm, bit_idx);
        rsub = (2*SAMPLE_W)'(w.res_den) << bit_idx;
        rrem = (2*SAMPLE_W)'(w.res_rem);
        if (rrem >= rsub)
        begin
            r.res_rem = SAMPLE_W'(rrem - rsub);
            r.res_quo = w.res_quo | (QUO_W'(1) << bit_idx);
        end
        return r;
    endfunction

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            assign valid_prev[k] = in_valid;
            assign word_next[k]  = ovf_check(in_word, div_mag);
        end
        else
        begin : g_step
            assign valid_prev[k] = valid_reg[k-1];
            assign word_next[k]  = div_step(word_reg[k-1], div_mag, QUO_W - k);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_prev[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                word_reg[k] <= word_next[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_word  = word_reg[STAGES-1];

endmodule

// File: hdl/tsc_output.sv
// ----------------------------------------------------------------------------
// Touch sample calibration output stage
// Clamps the coordinates unless in raw mode, signs the resistance and holds the
// result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module tsc_output #(
    parameter int SCREEN_WIDTH    = 320,
    parameter int SCREEN_HEIGHT   = 240,
    parameter int PRESS_THRESHOLD = 100
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                m_tready,
    input  logic                in_valid,
    input  tsc_pkg::div_word_t  in_word,
    input  tsc_pkg::calib_cfg_t cfg,
    output logic                advance,
    output logic                result_valid,
    output tsc_pkg::result_t    result
);
    import tsc_pkg::*;

    logic                    result_valid_reg;
    result_t                 result_reg;
    result_t                 result_next;
    logic                    calib_err;
    logic signed [RES_W-1:0] res_mag;
    logic signed [RES_W-1:0] res_val;

    function automatic logic [SAMPLE_W-1:0] clamp_axis(input axis_div_t a,
                                                       input logic [SAMPLE_W-1:0] top);
        logic [SAMPLE_W-1:0] r;
        if (!a.pos)
        begin
            r = '0;
        end
        else if (a.ovf || (a.quo > top))
        begin
            r = top;
        end
        else
        begin
            r = a.quo;
        end
        return r;
    endfunction

    assign calib_err = !cfg.raw_mode && (cfg.divisor == '0);
    assign res_mag   = $signed({1'b0, in_word.res_quo});
    assign res_val   = !in_word.res_valid ? '0 : (in_word.res_neg ? -res_mag : res_mag);

    always_comb
    begin
        if (cfg.raw_mode)
        begin
            result_next.pos_x = in_word.raw_x;
            result_next.pos_y = in_word.raw_y;
        end
        else if (calib_err)
        begin
            result_next.pos_x = '0;
            result_next.pos_y = '0;
        end
        else
        begin
            result_next.pos_x = clamp_axis(in_word.ax, SAMPLE_W'(SCREEN_WIDTH));
            result_next.pos_y = clamp_axis(in_word.ay, SAMPLE_W'(SCREEN_HEIGHT));
        end
        result_next.touch_resistance = res_val;
        result_next.resistance_valid = in_word.res_valid;
        result_next.pressed          = in_word.res_valid
                                       && (res_val < $signed(RES_W'(PRESS_THRESHOLD)));
        result_next.calib_error      = calib_err;
    end

    assign advance = !result_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: hdl/touch_sample_calibrate_core.sv
// ----------------------------------------------------------------------------
// Touch sample calibration core
// Resistive touch sample to calibrated, clamped screen position, touch
// resistance and press flag.
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         tvalid / tready     one raw touch sample
//   m_*       out        tvalid / tready     one calibrated result
//   cfg_*     in         cfg_wr_en only      calibration register write
//
// One sample is taken in every cycle while the output side keeps up.
// A result passes through seventeen register stages after its input transfer:
// three front-end stages, thirteen divider stages and the output register.
// The divider resolves one quotient bit per stage.
// Reset loads the calibration registers with their default matrix.
// A held output stalls the whole pipeline in place; nothing is lost.
// ----------------------------------------------------------------------------
`include "touch_sample_calibrate_core_defines.svh"

module touch_sample_calibrate_core #(
    parameter int SCREEN_WIDTH    = 320,
    parameter int SCREEN_HEIGHT   = 240,
    parameter int PRESS_THRESHOLD = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sample_x, sample_y, pressure_z1, pressure_z2
    input  logic [tsc_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pos_x, pos_y, touch_resistance, resistance_valid, pressed, calib_error
    output logic [tsc_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_wr_en,
    input  logic [tsc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::COEF_W-1:0]    cfg_data
);
    import tsc_pkg::*;

    calib_cfg_t          cfg_reg;
    logic [DIVM_W-1:0]   div_mag_reg;
    logic                advance;
    logic                front_valid;
    div_word_t           front_word;
    logic                div_valid;
    div_word_t           div_word;
    result_t             result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_COEF_A:   cfg_reg.coef_a   <= cfg_data;
                REG_COEF_B:   cfg_reg.coef_b   <= cfg_data;
                REG_COEF_C:   cfg_reg.coef_c   <= cfg_data;
                REG_COEF_D:   cfg_reg.coef_d   <= cfg_data;
                REG_COEF_E:   cfg_reg.coef_e   <= cfg_data;
                REG_COEF_F:   cfg_reg.coef_f   <= cfg_data;
                REG_DIVISOR:  cfg_reg.divisor  <= cfg_data;
                REG_RAW_MODE: cfg_reg.raw_mode <= cfg_data[0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        div_mag_reg <= cfg_reg.divisor[COEF_W-1] ? DIVM_W'(-cfg_reg.divisor)
                                                 : DIVM_W'(cfg_reg.divisor);
    end

    assign s_tready = advance;

    tsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (s_tvalid),
        .sample_x    (s_tdata[SAMPLE_W-1:0]),
        .sample_y    (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .pressure_z1 (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .pressure_z2 (s_tdata[4*SAMPLE_W-1:3*SAMPLE_W]),
        .cfg         (cfg_reg),
        .out_valid   (front_valid),
        .out_word    (front_word)
    );

    tsc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .div_mag   (div_mag_reg),
        .in_valid  (front_valid),
        .in_word   (front_word),
        .out_valid (div_valid),
        .out_word  (div_word)
    );

    tsc_output #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .PRESS_THRESHOLD (PRESS_THRESHOLD)
    ) u_output (
        .clk          (clk),
        .rst_n        (rst_n),
        .m_tready     (m_tready),
        .in_valid     (div_valid),
        .in_word      (div_word),
        .cfg          (cfg_reg),
        .advance      (advance),
        .result_valid (m_tvalid),
        .result       (result)
    );

    assign m_tdata = result;

    `ASSERT_IMPLIES(a_err_zero_pos, clk, rst_n, m_tvalid && result.calib_error, result.pos_x == '0 && result.pos_y == '0)
    `ASSERT_IMPLIES(a_invalid_res_zero, clk, rst_n, m_tvalid && !result.resistance_valid, result.touch_resistance == '0 && !result.pressed)
    `ASSERT_IMPLIES(a_clamped, clk, rst_n, m_tvalid && !cfg_reg.raw_mode, result.pos_x <= SAMPLE_W'(SCREEN_WIDTH) && result.pos_y <= SAMPLE_W'(SCREEN_HEIGHT))
    `ASSERT_NEVER(a_raw_no_err, clk, rst_n, m_tvalid && cfg_reg.raw_mode && result.calib_error)

endmodule
